@@ src/hbc_pkg.sv @@
package hbc_pkg;

  localparam int DEF_MAX_CELLS = 1024;
  localparam int DEF_MAX_NETS  = 1024;
  localparam int DEF_MAX_PINS  = 4096;

  localparam int CFG_W = 11;
  localparam int IDX_W = 10;
  localparam int DEG_W = 13;
  localparam int CUT_W = 11;
  localparam int BAL_W = 12;

  localparam logic [DEG_W-1:0] DEG_SAT = '1;
  localparam logic [CUT_W-1:0] CUT_SAT = '1;

  typedef enum logic [1:0] {
    CMD_ADD_PIN   = 2'd0,
    CMD_SET_SIDE  = 2'd1,
    CMD_FLIP_SIDE = 2'd2,
    CMD_QUERY     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_INDEX = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_ORDER     = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_CELL_COUNT = 1'b0,
    REG_NET_COUNT  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_QDONE
  } state_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [IDX_W-1:0] cell_index;
    logic [IDX_W-1:0] net_index;
    logic             side;
  } req_t;

  typedef struct packed {
    logic        [CUT_W-1:0] cut_nets;
    logic signed [BAL_W-1:0] balance;
    logic        [DEG_W-1:0] max_degree;
    status_t                 status;
  } rsp_t;

  typedef struct packed {
    logic             side;
    logic [DEG_W-1:0] degree;
  } cell_ent_t;

  typedef struct packed {
    logic [IDX_W-1:0] cell_id;
    logic [IDX_W-1:0] net;
  } pin_ent_t;

endpackage

@@ src/hbc_chan.sv @@
interface hbc_chan #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/hbc_cell_store.sv @@
module hbc_cell_store #(
  parameter int MAX_CELLS = hbc_pkg::DEF_MAX_CELLS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_CELLS)-1:0] wr_addr,
  input  hbc_pkg::cell_ent_t           wr_data,
  input  logic [$clog2(MAX_CELLS)-1:0] rd_addr,
  output hbc_pkg::cell_ent_t           rd_data,
  output logic                         clear_done
);
  import hbc_pkg::*;

  localparam int AW = $clog2(MAX_CELLS);

  cell_ent_t      mem [MAX_CELLS];
  logic [AW-1:0]  clr_addr;
  logic           clearing;

  // sweep every entry to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      if (clr_addr == AW'(MAX_CELLS - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign clear_done = !clearing;

endmodule

@@ src/hbc_pin_store.sv @@
module hbc_pin_store #(
  parameter int MAX_PINS = hbc_pkg::DEF_MAX_PINS
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [$clog2(MAX_PINS)-1:0] wr_addr,
  input  hbc_pkg::pin_ent_t           wr_data,
  input  logic [$clog2(MAX_PINS)-1:0] rd_addr,
  output hbc_pkg::pin_ent_t           rd_data
);
  import hbc_pkg::*;

  pin_ent_t mem [MAX_PINS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ src/hypergraph_bipartition_cut_counter.sv @@
// Two-way partition cut counter for a hypergraph kept as a pin list.
// Channels: req carries one command (add pin, set side, flip side, query);
// rsp returns exactly one result per command: cut count, balance, peak cell
// degree and status. Both use valid/ready; a transfer happens when both are
// high at a rising edge. cell_count and net_count are written through the
// cfg_we / cfg_index / cfg_data port; the user must do so only while the
// block is idle, as the block itself does not enforce it. Steps: for add,
// set and flip the cell entry is read in the accept cycle and written back
// when the result is loaded into the output register, once that register
// is free. A query streams the pin store through the cell store, one pin
// per cycle, via the pin store read, the cell store read and net grouping.
// Reset: all counters clear and the cell store (side bits and degrees) is
// swept to zero, one entry per cycle; req.ready stays low during the sweep,
// while configuration writes are taken as usual.
// Stall: a result waits in the output register until rsp.ready; the next
// command is still accepted and runs up to the point of its own result.
module hypergraph_bipartition_cut_counter #(
  parameter int MAX_CELLS = hbc_pkg::DEF_MAX_CELLS,
  parameter int MAX_NETS  = hbc_pkg::DEF_MAX_NETS,
  parameter int MAX_PINS  = hbc_pkg::DEF_MAX_PINS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [hbc_pkg::CFG_W-1:0] cfg_data,
  hbc_chan.sink                     req,
  hbc_chan.source                   rsp
);
  import hbc_pkg::*;

  localparam int CAW = $clog2(MAX_CELLS);
  localparam int PAW = $clog2(MAX_PINS);
  localparam int PCW = $clog2(MAX_PINS + 1);
  localparam int CFG_MAX = (2 ** CFG_W) - 1;
  localparam logic [CFG_W-1:0] CELL_LIM = (MAX_CELLS > CFG_MAX) ? '1 : CFG_W'(MAX_CELLS);
  localparam logic [CFG_W-1:0] NET_LIM  = (MAX_NETS > CFG_MAX) ? '1 : CFG_W'(MAX_NETS);
  localparam logic [PCW-1:0]   PIN_LIM  = PCW'(MAX_PINS);

  // configuration
  logic [CFG_W-1:0] cell_count;
  logic [CFG_W-1:0] net_count;
  logic [CFG_W-1:0] eff_cells;
  logic [CFG_W-1:0] eff_nets;

  // sequencer
  state_t state;
  state_t state_next;
  req_t   item;
  logic   accept;
  logic   fire;
  logic   out_free;
  logic   issue;

  // block state
  logic [PCW-1:0]   pins_loaded;
  logic [CFG_W-1:0] side_one_cells;
  logic [CFG_W-1:0] side_one_cells_next;
  logic [DEG_W-1:0] degree_peak;
  logic [DEG_W-1:0] degree_peak_next;
  logic [IDX_W-1:0] last_net;
  logic [CUT_W-1:0] cut_result;

  // query walk
  logic [PCW-1:0]   walk_idx;
  logic             s1_valid;
  logic             s2_valid;
  logic [IDX_W-1:0] net_s2;
  logic             grp_valid;
  logic [IDX_W-1:0] grp_net;
  logic             grp_has0;
  logic             grp_has1;
  logic [CUT_W-1:0] cut_acc;
  logic             cut_inc;
  logic [CUT_W-1:0] cut_final;

  // store ports
  logic             clear_done;
  logic [CAW-1:0]   cell_rd_addr;
  cell_ent_t        cell_rd;
  logic             cell_wr_en;
  cell_ent_t        cell_wr_data;
  logic             pin_wr_en;
  pin_ent_t         pin_wr_data;
  pin_ent_t         pin_rd;

  // command evaluation
  status_t          exec_status;
  logic             do_update;
  logic [DEG_W-1:0] deg_new;
  logic             new_side;
  logic signed [BAL_W:0]   bal_wide;
  logic signed [BAL_W-1:0] bal_sat;

  // output register
  logic out_valid;
  rsp_t out_data;
  rsp_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_count <= '0;
      net_count  <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_CELL_COUNT: cell_count <= cfg_data;
        REG_NET_COUNT:  net_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_cells = (cell_count < CELL_LIM) ? cell_count : CELL_LIM;
  assign eff_nets  = (net_count < NET_LIM) ? net_count : NET_LIM;

  hbc_cell_store #(
    .MAX_CELLS (MAX_CELLS)
  ) u_cell_store (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (cell_wr_en),
    .wr_addr    (CAW'(item.cell_index)),
    .wr_data    (cell_wr_data),
    .rd_addr    (cell_rd_addr),
    .rd_data    (cell_rd),
    .clear_done (clear_done)
  );

  hbc_pin_store #(
    .MAX_PINS (MAX_PINS)
  ) u_pin_store (
    .clk     (clk),
    .wr_en   (pin_wr_en),
    .wr_addr (pins_loaded[PAW-1:0]),
    .wr_data (pin_wr_data),
    .rd_addr (walk_idx[PAW-1:0]),
    .rd_data (pin_rd)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = (req.data.cmd == CMD_QUERY) ? S_WALK : S_EXEC;
      end
      S_EXEC: begin
        if (fire) state_next = S_IDLE;
      end
      S_WALK: begin
        if (!issue && !s1_valid && !s2_valid) state_next = S_QDONE;
      end
      S_QDONE: begin
        if (fire) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req.ready = (state == S_IDLE);
    accept    = req.valid && (state == S_IDLE);
    out_free  = !out_valid || rsp.ready;
    fire      = out_free && ((state == S_EXEC) || (state == S_QDONE));
    issue     = (state == S_WALK) && (walk_idx < pins_loaded);
    case (state)
      S_IDLE:  cell_rd_addr = CAW'(req.data.cell_index);
      S_WALK:  cell_rd_addr = CAW'(pin_rd.cell_id);
      default: cell_rd_addr = CAW'(item.cell_index);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item <= req.data;
  end

  // evaluate add/set/flip against the cell entry read in the accept cycle
  always_comb begin
    exec_status = STAT_OK;
    if (CFG_W'(item.cell_index) >= eff_cells) begin
      exec_status = STAT_BAD_INDEX;
    end else if (item.cmd == CMD_ADD_PIN) begin
      if (CFG_W'(item.net_index) >= eff_nets) begin
        exec_status = STAT_BAD_INDEX;
      end else if (pins_loaded >= PIN_LIM) begin
        exec_status = STAT_FULL;
      end else if ((pins_loaded != '0) && (item.net_index < last_net)) begin
        exec_status = STAT_ORDER;
      end
    end

    do_update = fire && (state == S_EXEC) && (exec_status == STAT_OK);
    deg_new   = (cell_rd.degree == DEG_SAT) ? cell_rd.degree : cell_rd.degree + 1'b1;
    new_side  = (item.cmd == CMD_SET_SIDE) ? item.side : ~cell_rd.side;

    cell_wr_en   = do_update;
    cell_wr_data = (item.cmd == CMD_ADD_PIN)
                   ? cell_ent_t'{side: cell_rd.side, degree: deg_new}
                   : cell_ent_t'{side: new_side, degree: cell_rd.degree};
    pin_wr_en    = do_update && (item.cmd == CMD_ADD_PIN);
    pin_wr_data  = '{cell_id: item.cell_index, net: item.net_index};

    side_one_cells_next = side_one_cells;
    degree_peak_next    = degree_peak;
    if (do_update) begin
      if (item.cmd == CMD_ADD_PIN) begin
        if (deg_new > degree_peak) degree_peak_next = deg_new;
      end else if (new_side != cell_rd.side) begin
        side_one_cells_next = new_side ? side_one_cells + 1'b1 : side_one_cells - 1'b1;
      end
    end

    // cells on side 0 minus side 1, clamped to the field range
    bal_wide = $signed({2'b00, eff_cells}) - $signed({1'b0, side_one_cells_next, 1'b0});
    if (bal_wide[BAL_W] != bal_wide[BAL_W-1]) begin
      bal_sat = bal_wide[BAL_W] ? {1'b1, {(BAL_W-1){1'b0}}} : {1'b0, {(BAL_W-1){1'b1}}};
    end else begin
      bal_sat = bal_wide[BAL_W-1:0];
    end

    // close the open net when a new net starts and at the end of a walk
    cut_inc   = grp_valid && grp_has0 && grp_has1 && (cut_acc != CUT_SAT);
    cut_final = cut_acc + CUT_W'(cut_inc);

    result.cut_nets   = (state == S_QDONE) ? cut_final : cut_result;
    result.balance    = bal_sat;
    result.max_degree = degree_peak_next;
    result.status     = (state == S_QDONE) ? STAT_OK : exec_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pins_loaded    <= '0;
      side_one_cells <= '0;
      degree_peak    <= '0;
      last_net       <= '0;
      cut_result     <= '0;
    end else begin
      side_one_cells <= side_one_cells_next;
      degree_peak    <= degree_peak_next;
      if (pin_wr_en) begin
        pins_loaded <= pins_loaded + 1'b1;
        last_net    <= item.net_index;
      end
      if (fire && (state == S_QDONE)) cut_result <= cut_final;
    end
  end

  // query walk: pin read, then cell side read, then net grouping
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      grp_valid <= 1'b0;
      walk_idx  <= '0;
      cut_acc   <= '0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      if (accept) begin
        walk_idx  <= '0;
        cut_acc   <= '0;
        grp_valid <= 1'b0;
      end else begin
        if (issue) walk_idx <= walk_idx + 1'b1;
        if (s2_valid) begin
          if (!grp_valid || (net_s2 != grp_net)) begin
            cut_acc   <= cut_final;
            grp_valid <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    net_s2 <= pin_rd.net;
    if (s2_valid) begin
      if (!grp_valid || (net_s2 != grp_net)) begin
        grp_net  <= net_s2;
        grp_has0 <= ~cell_rd.side;
        grp_has1 <= cell_rd.side;
      end else begin
        grp_has0 <= grp_has0 | ~cell_rd.side;
        grp_has1 <= grp_has1 | cell_rd.side;
      end
    end
  end

  // hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_data <= result;
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

endmodule
